>>> design/atsl_pkg.sv
// Shared constants and types for the address-to-symbol lookup block.
// No dependencies; atsl_if and the lookup core refer to this package by scoped names.
package atsl_pkg;

    // Default sizing of the symbol table.
    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_ADDRESS_WIDTH = 64;

    // Fixed widths of the channel fields.
    localparam int CMD_W       = 1;
    localparam int ENTRY_IDX_W = 10;
    localparam int FIELD_ADR_W = 64;
    localparam int COUNT_W     = 11;

    // Command codes carried by an input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

endpackage

>>> design/atsl_if.sv
// Channel interfaces of the address-to-symbol lookup block: input, result and register write.
// Depends on atsl_pkg for field widths and the command type.

// Input channel: one beat loads a table entry or requests a lookup.
interface atsl_in_if;
    logic                               valid;
    logic                               ready;
    atsl_pkg::t_cmd                     cmd;
    logic [atsl_pkg::ENTRY_IDX_W-1:0]   entry_index;
    logic [atsl_pkg::FIELD_ADR_W-1:0]   entry_address;
    logic [atsl_pkg::FIELD_ADR_W-1:0]   query_address;
    logic                               inside_body;

    modport source (output valid, cmd, entry_index, entry_address, query_address, inside_body,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_address, query_address, inside_body,
                    output ready);
endinterface

// Result channel: one beat per lookup.
interface atsl_out_if;
    logic                               valid;
    logic                               ready;
    logic [atsl_pkg::ENTRY_IDX_W-1:0]   result_index;
    logic [atsl_pkg::FIELD_ADR_W-1:0]   result_address;
    logic                               beyond_table;

    modport source (output valid, result_index, result_address, beyond_table, input ready);
    modport sink   (input valid, result_index, result_address, beyond_table, output ready);
endinterface

// Register write channel: carries the entry_count value.
interface atsl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [atsl_pkg::COUNT_W-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/atsl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module atsl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/address_to_symbol_lookup_core.sv
// Address-to-symbol lookup core (atsl_pkg, atsl_if, atsl_ram): lower-bound binary search.
// Load beat: written at its accept edge; a new beat can be taken on the next edge.
// Lookup beat: one probe per cycle on the RAM read port; the selected entry is then read and
// registered as the result once the result register is free, and no new beat is taken until
// the sequencer is back in its idle state, so a held result also holds the input.
// Synchronous active-low reset clears entry_count, sequencer and result valid; table undefined.
module address_to_symbol_lookup_core #(
    parameter int TABLE_DEPTH   = atsl_pkg::DEF_TABLE_DEPTH,
    parameter int ADDRESS_WIDTH = atsl_pkg::DEF_ADDRESS_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atsl_in_if.sink           i_in,
    atsl_out_if.source        o_out,
    atsl_cfg_if.sink          i_cfg
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_FINAL
    } t_state;

    t_state                          r_state;
    logic [atsl_pkg::COUNT_W-1:0]    r_entry_count;
    logic [ADDRESS_WIDTH-1:0]        r_query;
    logic                            r_inside;
    logic [SW-1:0]                   r_lo;
    logic [SW-1:0]                   r_hi;
    logic [SW-1:0]                   r_mid;
    logic [SW-1:0]                   r_sel;
    logic                            r_beyond;
    logic                            r_out_valid;
    logic [atsl_pkg::ENTRY_IDX_W-1:0] r_out_index;
    logic [atsl_pkg::FIELD_ADR_W-1:0] r_out_address;
    logic                            r_out_beyond;

    logic                     in_accept;
    logic                     lookup_start;
    logic                     load_wr;
    logic                     out_load;
    logic [SW-1:0]            count_clamped;
    logic [SW-1:0]            n_lo;
    logic [SW-1:0]            n_hi;
    logic [SW-1:0]            n_mid;
    logic                     n_search;
    logic                     n_beyond;
    logic [SW-1:0]            n_base;
    logic [SW-1:0]            n_sel;
    logic                     cur_inside;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic [ADDRESS_WIDTH-1:0] rd_data;

    // Handshake decode.
    assign in_accept    = i_in.valid && i_in.ready;
    assign lookup_start = in_accept && (i_in.cmd == atsl_pkg::CMD_LOOKUP);
    assign load_wr      = in_accept && (i_in.cmd == atsl_pkg::CMD_LOAD)
                          && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    // The selected entry moves into the result register once that register is free.
    assign out_load = (r_state == S_FINAL) && (!r_out_valid || o_out.ready);

    // Entry count limited to the table depth.
    assign count_clamped = (32'(r_entry_count) > TABLE_DEPTH) ? SW'(TABLE_DEPTH)
                                                             : SW'(r_entry_count);

    // Search step: bounds after the current probe, the next probe and the final pick.
    always_comb begin
        n_lo       = '0;
        n_hi       = count_clamped;
        cur_inside = i_in.inside_body;
        if (r_state != S_IDLE) begin
            cur_inside = r_inside;
            n_lo       = r_lo;
            n_hi       = r_hi;
            if (r_state == S_PROBE) begin
                if (r_query <= rd_data) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + SW'(1);
                end
            end
        end
        n_mid    = n_lo + ((n_hi - n_lo) >> 1);
        n_search = (n_lo < n_hi);
        n_beyond = (n_hi == count_clamped);
        n_base   = n_beyond ? '0 : n_hi;
        n_sel    = (cur_inside && (n_base != '0)) ? (n_base - SW'(1)) : n_base;
    end

    // Read the next probe while searching, the selected entry once done.
    assign rd_en   = lookup_start || (r_state == S_PROBE);
    assign rd_addr = n_search ? IW'(n_mid) : IW'(n_sel);

    atsl_ram #(
        .WIDTH (ADDRESS_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (IW'(i_in.entry_index)),
        .i_wr_data (i_in.entry_address[ADDRESS_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer, register file and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_entry_count <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (lookup_start) begin
                        r_query  <= i_in.query_address[ADDRESS_WIDTH-1:0];
                        r_inside <= i_in.inside_body;
                        r_lo     <= n_lo;
                        r_hi     <= n_hi;
                        r_mid    <= n_mid;
                        r_sel    <= n_sel;
                        r_beyond <= n_beyond;
                        r_state  <= n_search ? S_PROBE : S_FINAL;
                    end
                end
                S_PROBE: begin
                    r_lo     <= n_lo;
                    r_hi     <= n_hi;
                    r_mid    <= n_mid;
                    r_sel    <= n_sel;
                    r_beyond <= n_beyond;
                    r_state  <= n_search ? S_PROBE : S_FINAL;
                end
                S_FINAL: begin
                    // Hold the selected entry until the result register is free.
                    if (out_load) begin
                        r_out_index   <= atsl_pkg::ENTRY_IDX_W'(r_sel);
                        r_out_address <= atsl_pkg::FIELD_ADR_W'(rd_data);
                        r_out_beyond  <= r_beyond;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_index   = r_out_index;
    assign o_out.result_address = r_out_address;
    assign o_out.beyond_table   = r_out_beyond;

endmodule

>>> tb/address_to_symbol_lookup_core_tb.sv
// Testbench for address_to_symbol_lookup_core: drives load and lookup beats, predicts each
// lookup with its own lower-bound search over a mirror of the table, and checks every result.
// Depends on atsl_pkg, the channel interfaces in atsl_if and the core itself.
module address_to_symbol_lookup_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH   = atsl_pkg::DEF_TABLE_DEPTH;
    localparam int          IDX_W         = atsl_pkg::ENTRY_IDX_W;
    localparam int          ADR_W         = atsl_pkg::FIELD_ADR_W;
    localparam int          CNT_W         = atsl_pkg::COUNT_W;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_BEATS  = 600;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          MAX_REPORTS   = 50;

    // One selected table entry, as the result channel carries it.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ADR_W-1:0] address;
        logic             beyond;
    } t_hit;

    // One input beat.
    typedef struct {
        atsl_pkg::t_cmd   cmd;
        logic [IDX_W-1:0] slot;
        logic [ADR_W-1:0] entry_adr;
        logic [ADR_W-1:0] query;
        logic             in_body;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    atsl_in_if  in_ch ();
    atsl_out_if out_ch ();
    atsl_cfg_if cfg_ch ();

    address_to_symbol_lookup_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the symbol table and the count register.
    logic [ADR_W-1:0] sym_start [TABLE_DEPTH];
    logic [CNT_W-1:0] entry_count_model;
    t_hit             pending_hits [$];

    int unsigned beats_sent;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int          long_hold;
    int          stall_left;
    bit          idling_on;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Lower-bound search over the mirrored table, then the fallback and inside-body step.
    function automatic t_hit lower_bound_pick(input logic [ADR_W-1:0] q,
                                              input logic in_body);
        int unsigned span, lo, hi, mid, pick;
        t_hit        h;
        span = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_model;
        lo = 0;
        hi = span;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (q <= sym_start[mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        h.beyond = (hi == span);
        pick = h.beyond ? 0 : hi;
        if (in_body && pick != 0) begin
            pick = pick - 1;
        end
        h.index   = pick[IDX_W-1:0];
        h.address = sym_start[pick];
        return h;
    endfunction

    // Unused fields of a beat carry random bits.
    function automatic t_beat make_load(input logic [IDX_W-1:0] slot,
                                        input logic [ADR_W-1:0] adr);
        t_beat b;
        b.cmd       = atsl_pkg::CMD_LOAD;
        b.slot      = slot;
        b.entry_adr = adr;
        b.query     = rand64();
        b.in_body   = rand_bit();
        return b;
    endfunction

    function automatic t_beat make_lookup(input logic [ADR_W-1:0] q, input logic in_body);
        t_beat b;
        b.cmd       = atsl_pkg::CMD_LOOKUP;
        b.slot      = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        b.entry_adr = rand64();
        b.query     = q;
        b.in_body   = in_body;
        return b;
    endfunction

    // A query near a valid entry, at an extreme, or anywhere.
    function automatic logic [ADR_W-1:0] pick_query(input int unsigned count);
        int unsigned      span, k;
        logic [ADR_W-1:0] e;
        span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        k = (span == 0) ? 0 : $urandom_range(0, span - 1);
        e = sym_start[k];
        case ($urandom_range(0, 6))
            0, 1: return e;
            2: return e + 1;
            3: return e - 1;
            4: return '1;
            5: return '0;
            default: return rand64();
        endcase
    endfunction

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // Offers one beat, waits for it to be taken and updates the mirror.
    task automatic send_beat(input t_beat b);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= b.cmd;
        in_ch.entry_index   <= b.slot;
        in_ch.entry_address <= b.entry_adr;
        in_ch.query_address <= b.query;
        in_ch.inside_body   <= b.in_body;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        beats_sent++;
        if (b.cmd == atsl_pkg::CMD_LOAD) begin
            sym_start[b.slot] = b.entry_adr;
        end else begin
            pending_hits.push_back(lower_bound_pick(b.query, b.in_body));
        end
    endtask

    // Waits until every lookup has answered and any trailing load has settled.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_entry_count(input logic [CNT_W-1:0] value);
        drain_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        entry_count_model = value;
    endtask

    // Loads slots 0..n-1 with ascending addresses; zero steps give duplicates.
    task automatic load_sorted_table(input int unsigned n, input int unsigned min_shift);
        logic [ADR_W-1:0] adr, step;
        case ($urandom_range(0, 2))
            0: adr = '0;
            1: adr = {32'h0, $urandom};
            default: adr = rand64() >> $urandom_range(1, 63);
        endcase
        for (int unsigned s = 0; s < n; s++) begin
            send_beat(make_load(IDX_W'(s), adr));
            step = ($urandom_range(0, 7) == 0) ? '0 : rand64() >> $urandom_range(min_shift, 63);
            adr  = (adr + step < adr) ? '1 : adr + step;
        end
    endtask

    // Result checker: each beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_hits.size() == 0) begin
                log_mismatch("unexpected result_index", out_ch.result_index, '0);
            end else begin
                want = pending_hits.pop_front();
                if (out_ch.result_index !== want.index) begin
                    log_mismatch("result_index", out_ch.result_index, want.index);
                end
                if (out_ch.result_address !== want.address) begin
                    log_mismatch("result_address", out_ch.result_address, want.address);
                end
                if (out_ch.beyond_table !== want.beyond) begin
                    log_mismatch("beyond_table", out_ch.beyond_table, want.beyond);
                end
            end
        end
    end

    // Result receiver: random stall bursts, plus a long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                out_ch.ready <= 1'b0;
                long_hold--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // With only slot 0 loaded the table is empty at the reset count and at count zero.
    task automatic test_empty_table();
        send_beat(make_load('0, '0));
        send_beat(make_lookup('0, 1'b0));
        send_beat(make_lookup('1, 1'b1));
        configure_entry_count('0);
        send_beat(make_lookup(64'h1234, 1'b0));
    endtask

    // Exact hits, queries between entries and the inside-body step.
    task automatic test_ordered_lookups();
        send_beat(make_load(IDX_W'(1), 64'h100));
        send_beat(make_load(IDX_W'(2), 64'h8000_0000_0000_0000));
        send_beat(make_load(IDX_W'(3), '1));
        configure_entry_count(CNT_W'(4));
        send_beat(make_lookup('0, 1'b0));
        send_beat(make_lookup(64'h100, 1'b0));
        send_beat(make_lookup(64'h101, 1'b0));
        send_beat(make_lookup(64'h101, 1'b1));
        send_beat(make_lookup('1, 1'b0));
        send_beat(make_lookup('1, 1'b1));
        send_beat(make_lookup('0, 1'b1));
    endtask

    // Queries above every valid entry fall back to slot 0.
    task automatic test_beyond_table();
        configure_entry_count(CNT_W'(3));
        send_beat(make_lookup('1, 1'b0));
        send_beat(make_lookup('1, 1'b1));
        configure_entry_count(CNT_W'(1));
        send_beat(make_lookup(64'h1, 1'b0));
        send_beat(make_lookup(64'h1, 1'b1));
    endtask

    // A table out of order still follows the probe sequence exactly.
    task automatic test_unordered_table();
        configure_entry_count(CNT_W'(4));
        send_beat(make_load(IDX_W'(1), 64'hFFFF_0000_0000_0000));
        send_beat(make_lookup(64'h101, 1'b0));
        send_beat(make_lookup(64'h9000_0000_0000_0000, 1'b1));
        send_beat(make_load(IDX_W'(1), 64'h100));
    endtask

    // The receiver holds off for a long stretch while lookups keep coming.
    task automatic test_backpressure();
        idling_on = 1'b0;
        long_hold = 300;
        repeat (30) begin
            send_beat(make_lookup(pick_query(4), rand_bit()));
        end
        drain_block();
        idling_on = 1'b1;
    endtask

    // Every slot loaded; counts just below, at and above the table depth.
    task automatic test_full_table();
        logic [CNT_W-1:0] counts [5];
        counts = '{CNT_W'(TABLE_DEPTH), CNT_W'(TABLE_DEPTH - 1), CNT_W'(TABLE_DEPTH + 1), '1,
                   CNT_W'($urandom_range(TABLE_DEPTH + 2, 2046))};
        load_sorted_table(TABLE_DEPTH, 12);
        foreach (counts[c]) begin
            configure_entry_count(counts[c]);
            repeat (14) begin
                send_beat(make_lookup(pick_query(counts[c]), rand_bit()));
            end
        end
    endtask

    // Random tables, mostly small, with lookups and occasional stray loads.
    task automatic test_random_traffic();
        int unsigned start_beats, n, count, probes;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            if (beats_sent - start_beats > RANDOM_BEATS * 4 / 5) begin
                idling_on = 1'b0;
            end else begin
                idling_on = ($urandom_range(0, 4) != 0);
            end
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(129, 400);
                1, 2, 3: n = $urandom_range(17, 128);
                default: n = $urandom_range(1, 16);
            endcase
            load_sorted_table(n, 8);
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n;
            configure_entry_count(CNT_W'(count));
            probes = $urandom_range(8, 40);
            repeat (probes) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_beat(make_load(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand64()));
                end else begin
                    send_beat(make_lookup(pick_query(count), rand_bit()));
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.cmd           <= atsl_pkg::CMD_LOAD;
        in_ch.entry_index   <= '0;
        in_ch.entry_address <= '0;
        in_ch.query_address <= '0;
        in_ch.inside_body   <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        cycle_count         = 0;
        beats_sent          = 0;
        mismatch_count      = 0;
        long_hold           = 0;
        stall_left          = 0;
        idling_on           = 1'b1;
        entry_count_model   = '0;
        foreach (sym_start[s]) sym_start[s] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_ordered_lookups();
        test_beyond_table();
        test_unordered_table();
        test_backpressure();
        test_full_table();
        test_random_traffic();

        drain_block();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/atsl_pkg.sv
design/atsl_if.sv
design/atsl_ram.sv
design/address_to_symbol_lookup_core.sv
tb/address_to_symbol_lookup_core_tb.sv
